>>> hw/rtl/greedy_bandit_sample_average_core_macros.svh
// ----------------------------------------------------------------------------
// Greedy bandit core assertion macros
// Shared concurrent assertion forms used by the RTL of the bandit core.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BANDIT_SAMPLE_AVERAGE_CORE_MACROS_SVH
`define GREEDY_BANDIT_SAMPLE_AVERAGE_CORE_MACROS_SVH

// same-cycle implication
`define GBSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbsa: assertion failed");

// next-cycle implication
`define GBSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbsa: assertion failed");

`endif

>>> hw/rtl/gbsa_pkg.sv
// ----------------------------------------------------------------------------
// Greedy bandit package
// Sizes, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbsa_pkg;

    localparam int ARMS       = 16;
    localparam int ARM_W      = $clog2(ARMS);
    localparam int SIDX_W     = ARM_W + 1;
    localparam int FIELD_ARM_W = 4;
    localparam int EST_W      = 16;
    localparam int CNT_W      = 16;
    localparam int DIV_W      = EST_W + 1;
    localparam int DIV_STEPS  = DIV_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int AIU_W      = 5;
    localparam int BEST_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ARMS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BEST_ARM    = CFG_IDX_W'(1);

    localparam logic [AIU_W-1:0]  AIU_RESET  = AIU_W'(10);
    localparam logic [BEST_W-1:0] BEST_RESET = BEST_W'(2);
    localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

    typedef struct packed {
        logic capture;
        logic load;
        logic step;
        logic update;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hw/rtl/gbsa_if.sv
// ----------------------------------------------------------------------------
// Greedy bandit channel interfaces
// Reward input, result output and register write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gbsa_in_if;
    import gbsa_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [EST_W-1:0]  reward;
    modport source (output valid, kind, reward, input ready);
    modport sink   (input valid, kind, reward, output ready);
endinterface

interface gbsa_out_if;
    import gbsa_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [FIELD_ARM_W-1:0]   rewarded_arm;
    logic                     hit_best;
    logic signed [EST_W-1:0]  new_estimate;
    logic [FIELD_ARM_W-1:0]   next_arm;
    modport source (output valid, rewarded_arm, hit_best, new_estimate, next_arm,
                    input ready);
    modport sink   (input valid, rewarded_arm, hit_best, new_estimate, next_arm,
                    output ready);
endinterface

interface gbsa_cfg_if;
    import gbsa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/greedy_bandit_sample_average_core.sv
// ----------------------------------------------------------------------------
// Greedy bandit core, sample-average estimates
// Top level: controller, datapath and channel wiring.
// ----------------------------------------------------------------------------
// A reward transaction holds the core through the accepting cycle, a fetch
// of the current arm's estimate and count, the one-bit-per-cycle restoring
// divider, and a write-back that posts the result to the output register.
// The argmax scan over the other arms runs one arm per cycle beside the
// divider. A clear transaction holds it through the accepting cycle and a
// clear that posts its result. One transaction is in work at a time; a new
// one is taken while the previous result still waits in the output register,
// and its write-back cycle is stretched until that result has gone. Register
// writes are taken in any cycle and belong between transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_bandit_sample_average_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gbsa_in_if.sink     i_in,
    gbsa_out_if.source  o_out,
    gbsa_cfg_if.sink    i_cfg
);
    import gbsa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    gbsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    gbsa_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_reward       (i_in.reward),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_rewarded_arm (o_out.rewarded_arm),
        .o_hit_best     (o_out.hit_best),
        .o_new_estimate (o_out.new_estimate),
        .o_next_arm     (o_out.next_arm)
    );

endmodule

`default_nettype wire

>>> hw/rtl/gbsa_ctrl.sv
// ----------------------------------------------------------------------------
// Greedy bandit controller
// Sequences fetch, divide, update and clear; owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_bandit_sample_average_core_macros.svh"

module gbsa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_kind,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output gbsa_pkg::t_dp_cmd     o_cmd,
    input  wire gbsa_pkg::t_dp_sts i_sts
);
    import gbsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_UPD,
        S_CLR
    } t_state;

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_ovalid, n_ovalid;
    logic               out_free;
    logic               posting;

    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign posting     = o_cmd.update || o_cmd.clear;

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.load    = (r_state == S_LOAD);
        o_cmd.step    = (r_state == S_DIV);
        o_cmd.update  = (r_state == S_UPD) && out_free;
        o_cmd.clear   = (r_state == S_CLR) && out_free;
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_ovalid = r_ovalid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_kind ? S_CLR : S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1) && i_sts.scan_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD, S_CLR: begin
                if (out_free) begin
                    n_state  = S_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    `GBSA_ASSERT_NXT(a_reward_fetch, i_clk, i_rst_n, o_cmd.capture && !i_in_kind, r_state == S_LOAD)
    `GBSA_ASSERT_IMP(a_scan_before_update, i_clk, i_rst_n, o_cmd.update, i_sts.scan_done)
    `GBSA_ASSERT_NXT(a_result_posted, i_clk, i_rst_n, posting, r_ovalid && r_state == S_IDLE)
    `GBSA_ASSERT_IMP(a_valid_source, i_clk, i_rst_n, $rose(r_ovalid), $past(posting))

endmodule

`default_nettype wire

>>> hw/rtl/gbsa_datapath.sv
// ----------------------------------------------------------------------------
// Greedy bandit datapath
// Estimate and count registers, restoring divider, argmax scan, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbsa_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire gbsa_pkg::t_dp_cmd                 i_cmd,
    output gbsa_pkg::t_dp_sts                      o_sts,
    input  wire logic signed [gbsa_pkg::EST_W-1:0] i_reward,
    input  wire logic                              i_cfg_valid,
    input  wire logic [gbsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gbsa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [gbsa_pkg::FIELD_ARM_W-1:0]       o_rewarded_arm,
    output logic                                   o_hit_best,
    output logic signed [gbsa_pkg::EST_W-1:0]      o_new_estimate,
    output logic [gbsa_pkg::FIELD_ARM_W-1:0]       o_next_arm
);
    import gbsa_pkg::*;

    logic signed [EST_W-1:0] r_est [ARMS];
    logic [CNT_W-1:0]        r_cnt [ARMS];
    logic [ARM_W-1:0]        r_cur;
    logic [AIU_W-1:0]        r_aiu;
    logic [BEST_W-1:0]       r_best;

    logic signed [EST_W-1:0] r_reward;
    logic [ARM_W-1:0]        r_arm;
    logic signed [EST_W-1:0] r_old;
    logic                    r_neg;
    logic [DIV_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_dvs;

    logic [SIDX_W-1:0]       r_sidx;
    logic                    r_have;
    logic signed [EST_W-1:0] r_bval;
    logic [ARM_W-1:0]        r_bidx;

    logic [ARM_W-1:0]        rd_addr;
    logic signed [EST_W-1:0] est_rd;
    logic [CNT_W-1:0]        cnt_rd;
    logic [CNT_W-1:0]        cnt_new;
    logic signed [DIV_W-1:0] diff;
    logic [DIV_W-1:0]        diff_mag;
    logic [DIV_W-1:0]        trial;
    logic                    trial_ok;
    logic [SIDX_W-1:0]       live_n;
    logic                    scan_take;
    logic signed [DIV_W:0]   quo_s;
    logic signed [DIV_W:0]   est_sum;
    logic signed [EST_W-1:0] est_new;
    logic                    new_wins;
    logic [ARM_W-1:0]        next_arm;

    assign rd_addr = i_cmd.load ? r_cur : r_sidx[ARM_W-1:0];
    assign est_rd  = r_est[rd_addr];
    assign cnt_rd  = r_cnt[r_cur];
    assign cnt_new = (cnt_rd == CNT_MAX) ? CNT_MAX : cnt_rd + CNT_W'(1);

    assign diff     = $signed({r_reward[EST_W-1], r_reward})
                      - $signed({est_rd[EST_W-1], est_rd});
    assign diff_mag = diff[DIV_W-1] ? DIV_W'(-diff) : DIV_W'(diff);

    assign trial    = {r_rem, r_quo[DIV_W-1]};
    assign trial_ok = (trial >= {1'b0, r_dvs});

    always_comb begin
        if (r_aiu == '0) begin
            live_n = SIDX_W'(1);
        end else if ({{(SIDX_W + AIU_W){1'b0}}, r_aiu} > (SIDX_W + AIU_W + AIU_W)'(ARMS)) begin
            live_n = SIDX_W'(ARMS);
        end else begin
            live_n = SIDX_W'(r_aiu);
        end
    end

    assign scan_take = (r_sidx < SIDX_W'(ARMS)) && (r_sidx < live_n)
                       && (r_sidx[ARM_W-1:0] != r_arm)
                       && (!r_have || est_rd > r_bval);

    assign quo_s   = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign est_sum = $signed({{2{r_old[EST_W-1]}}, r_old}) + quo_s;
    assign est_new = est_sum[EST_W-1:0];

    assign new_wins = ({1'b0, r_arm} < live_n)
                      && (!r_have || est_new > r_bval
                          || (est_new == r_bval && r_arm < r_bidx));
    assign next_arm = new_wins ? r_arm : r_bidx;

    assign o_sts.scan_done = (r_sidx >= SIDX_W'(ARMS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < ARMS; a++) begin
                r_est[a] <= '0;
                r_cnt[a] <= '0;
            end
            r_cur  <= '0;
            r_aiu  <= AIU_RESET;
            r_best <= BEST_RESET;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ARMS_IN_USE: r_aiu  <= i_cfg_data[AIU_W-1:0];
                    REG_BEST_ARM:    r_best <= i_cfg_data[BEST_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                for (int a = 0; a < ARMS; a++) begin
                    r_est[a] <= '0;
                    r_cnt[a] <= '0;
                end
                r_cur <= '0;
            end
            if (i_cmd.load) begin
                r_cnt[r_cur] <= cnt_new;
            end
            if (i_cmd.update) begin
                r_est[r_arm] <= est_new;
                r_cur        <= next_arm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_reward <= i_reward;
        end
        if (i_cmd.load) begin
            r_arm  <= r_cur;
            r_old  <= est_rd;
            r_neg  <= diff[DIV_W-1];
            r_quo  <= diff_mag;
            r_rem  <= '0;
            r_dvs  <= cnt_new;
            r_sidx <= '0;
            r_have <= 1'b0;
        end
        if (i_cmd.step) begin
            r_quo <= {r_quo[DIV_W-2:0], trial_ok};
            r_rem <= trial_ok ? CNT_W'(trial - {1'b0, r_dvs}) : trial[CNT_W-1:0];
            if (!o_sts.scan_done) begin
                r_sidx <= r_sidx + SIDX_W'(1);
                if (scan_take) begin
                    r_have <= 1'b1;
                    r_bval <= est_rd;
                    r_bidx <= r_sidx[ARM_W-1:0];
                end
            end
        end
        if (i_cmd.update) begin
            o_rewarded_arm <= FIELD_ARM_W'(r_arm);
            o_hit_best     <= (BEST_W'(r_arm) == r_best);
            o_new_estimate <= est_new;
            o_next_arm     <= FIELD_ARM_W'(next_arm);
        end else if (i_cmd.clear) begin
            o_rewarded_arm <= '0;
            o_hit_best     <= 1'b0;
            o_new_estimate <= '0;
            o_next_arm     <= '0;
        end
    end

endmodule

`default_nettype wire
